// ----- rtl/cvsd_pkg.sv -----
package cvsd_pkg;

    localparam int FIR_TAPS  = 57;
    localparam int TAP_W     = $clog2(FIR_TAPS);
    localparam int CMP_STEPS = 15;

    localparam logic [16:0] STEP_MIN    = 17'd2726;
    localparam logic [16:0] STEP_MAX    = 17'd71788;
    localparam logic [3:0]  HIST_RESET  = 4'd10;
    localparam logic [13:0] PCM_GAIN    = 14'd10000;

    // configuration register indexes
    localparam logic [1:0] CFG_HISTORY_BITS = 2'd0;
    localparam logic [1:0] CFG_CHARGE_COEF  = 2'd1;
    localparam logic [1:0] CFG_DECAY_COEF   = 2'd2;
    localparam logic [1:0] CFG_LEAK_COEF    = 2'd3;

    // every FIR coefficient is +/- a power of two: shift amount and sign
    localparam logic [3:0] FIR_SHIFT [FIR_TAPS] = '{
        4'd3, 4'd2, 4'd4, 4'd5, 4'd4, 4'd4, 4'd6, 4'd6, 4'd2, 4'd6,
        4'd7, 4'd5, 4'd7, 4'd7, 4'd7, 4'd6, 4'd8, 4'd8, 4'd3, 4'd8,
        4'd9, 4'd7, 4'd9, 4'd10, 4'd9, 4'd9, 4'd11, 4'd12, 4'd12, 4'd12,
        4'd11, 4'd9, 4'd9, 4'd10, 4'd9, 4'd7, 4'd9, 4'd8, 4'd3, 4'd8,
        4'd8, 4'd6, 4'd7, 4'd7, 4'd7, 4'd5, 4'd7, 4'd6, 4'd2, 4'd6,
        4'd6, 4'd4, 4'd4, 4'd5, 4'd4, 4'd2, 4'd3
    };

    localparam logic FIR_NEG [FIR_TAPS] = '{
        1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
        1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
        1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
        1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0
    };

    typedef struct packed {
        logic [7:0] data_byte;
        logic       run_start;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic               last_of_byte;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic clear;
    } ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC,
        ST_CMP,
        ST_FIR,
        ST_OUT
    } state_t;

endpackage

// ----- rtl/cvsd_dec.sv -----
module cvsd_dec
    import cvsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctl_t               ctl,
    input  logic               bit_in,
    input  logic [2:0]         history_bits,
    input  logic [15:0]        charge_coef,
    input  logic [15:0]        decay_coef,
    input  logic [15:0]        leak_coef,
    output stat_t              stat,
    output logic signed [31:0] integ
);

    logic [3:0]         hist_reg;
    logic [16:0]        step_reg;
    logic signed [31:0] integ_reg;
    logic [31:0]        sum_reg;
    logic               leak_reg;
    logic               done_reg;

    logic [3:0]  mask;
    logic [3:0]  hist_new;
    logic        run;
    logic [33:0] step_ext;
    logic [33:0] sum_wide;
    logic [31:0] sum_sat;
    logic [16:0] diff;
    logic [32:0] cprod;
    logic [17:0] cstep;
    logic [32:0] dprod;
    logic [16:0] step_new;
    logic [31:0] lmag_in;
    logic [47:0] lprod;
    logic [31:0] integ_new;

    always_comb
    begin
        mask     = (history_bits >= 3'd4) ? 4'hF : 4'h7;
        hist_new = {hist_reg[2:0], bit_in} & mask;
        run      = (hist_new == 4'd0) || (hist_new == mask);

        step_ext = {17'd0, step_reg};
        sum_wide = {{2{integ_reg[31]}}, integ_reg} + (bit_in ? step_ext : (34'd0 - step_ext));
        if (!sum_wide[33] && (sum_wide[32:31] != 2'b00))
            sum_sat = 32'h7FFF_FFFF;
        else if (sum_wide[33] && (sum_wide[32:31] != 2'b11))
            sum_sat = 32'h8000_0000;
        else
            sum_sat = sum_wide[31:0];

        diff  = STEP_MAX - step_reg;
        cprod = diff * charge_coef;
        cstep = {1'b0, STEP_MAX} - {1'b0, cprod[32:16]};
        dprod = step_reg * decay_coef;
        if (run)
        begin
            if (cstep > {1'b0, STEP_MAX})
                step_new = STEP_MAX;
            else if (cstep < {1'b0, STEP_MIN})
                step_new = STEP_MIN;
            else
                step_new = cstep[16:0];
        end
        else
        begin
            if (dprod[32:16] < STEP_MIN)
                step_new = STEP_MIN;
            else
                step_new = dprod[32:16];
        end

        // leak: magnitude times coefficient, truncated toward zero
        lmag_in   = sum_reg[31] ? (32'd0 - sum_reg) : sum_reg;
        lprod     = lmag_in * leak_coef;
        integ_new = sum_reg[31] ? (32'd0 - lprod[47:16]) : lprod[47:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg  <= HIST_RESET;
            step_reg  <= STEP_MIN;
            integ_reg <= '0;
            leak_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.clear)
            begin
                hist_reg  <= HIST_RESET;
                step_reg  <= STEP_MIN;
                integ_reg <= '0;
            end
            else if (ctl.start)
            begin
                hist_reg <= hist_new;
                step_reg <= step_new;
                leak_reg <= 1'b1;
            end
            else if (leak_reg)
            begin
                integ_reg <= $signed(integ_new);
                leak_reg  <= 1'b0;
                done_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
            sum_reg <= sum_sat;
    end

    assign stat.busy = leak_reg;
    assign stat.done = done_reg;
    assign integ     = integ_reg;

endmodule

// ----- rtl/cvsd_cmp.sv -----
module cvsd_cmp
    import cvsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] integ,
    output stat_t              stat,
    output logic signed [15:0] sample
);

    logic        busy_reg;
    logic        load_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic        neg_reg;
    logic [44:0] mag_reg;
    logic [46:0] rem_reg;
    logic [45:0] div_reg;
    logic [14:0] q_reg;

    logic [31:0] abs_in;
    logic [45:0] gprod;
    logic [46:0] rem_sh;
    logic        ge;

    always_comb
    begin
        abs_in = integ[31] ? (32'd0 - integ) : integ;
        gprod  = abs_in * PCM_GAIN;
        rem_sh = {rem_reg[45:0], 1'b0};
        ge     = rem_sh >= {1'b0, div_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            load_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                load_reg <= 1'b1;
            end
            else if (load_reg)
            begin
                load_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(CMP_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring divide: q = mag * 2^15 / (mag + 2^31), one bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mag_reg <= gprod[44:0];
            neg_reg <= integ[31];
        end
        else if (load_reg)
        begin
            rem_reg <= {2'b00, mag_reg};
            div_reg <= {1'b0, mag_reg} + 46'h0000_8000_0000;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, div_reg}) : rem_sh;
            q_reg   <= {q_reg[13:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign sample    = neg_reg ? $signed(16'd0 - {1'b0, q_reg}) : $signed({1'b0, q_reg});

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !load_reg) |-> (rem_reg < {1'b0, div_reg}))
        else $error("divider remainder not below divisor");

endmodule

// ----- rtl/cvsd_fir.sv -----
module cvsd_fir
    import cvsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ctl_t               ctl,
    input  logic signed [15:0] sample,
    output stat_t              stat,
    output logic signed [15:0] y
);

    logic signed [15:0] hist_reg [FIR_TAPS];
    logic [TAP_W-1:0]   tap_reg;
    logic               busy_reg;
    logic               done_reg;
    logic signed [31:0] acc_reg;

    logic signed [31:0] term;
    logic signed [31:0] acc_next;
    logic signed [17:0] acc_q;

    always_comb
    begin
        term     = {{16{hist_reg[0][15]}}, hist_reg[0]} <<< FIR_SHIFT[tap_reg];
        acc_next = FIR_NEG[tap_reg] ? (acc_reg - term) : (acc_reg + term);
        acc_q    = acc_reg[31:14];
        if ((acc_q[17:15] == 3'b000) || (acc_q[17:15] == 3'b111))
            y = acc_q[15:0];
        else if (acc_q[17])
            y = 16'sh8000;
        else
            y = 16'sh7FFF;
    end

    // history is a ring: push on start, then one full rotation while summing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FIR_TAPS; i++)
                hist_reg[i] <= '0;
            tap_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.clear)
            begin
                for (int i = 0; i < FIR_TAPS; i++)
                    hist_reg[i] <= '0;
            end
            else if (ctl.start)
            begin
                for (int i = 1; i < FIR_TAPS; i++)
                    hist_reg[i] <= hist_reg[i-1];
                hist_reg[0] <= sample;
                tap_reg     <= '0;
                busy_reg    <= 1'b1;
            end
            else if (busy_reg)
            begin
                for (int i = 0; i < FIR_TAPS - 1; i++)
                    hist_reg[i] <= hist_reg[i+1];
                hist_reg[FIR_TAPS-1] <= hist_reg[0];
                tap_reg <= tap_reg + 1'b1;
                if (tap_reg == TAP_W'(FIR_TAPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
            acc_reg <= '0;
        else if (busy_reg)
            acc_reg <= acc_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- rtl/cvsd_decoder_fir_postfilter_top.sv -----
// CVSD byte decoder with a 57-tap post-filter.
// Input channel (in_valid/in_ready/in_data): one item is a CVSD byte plus a
// run_start flag; bits are decoded LSB first. run_start clears the integrator,
// step size, bit history and filter history before the byte is decoded.
// Output channel (out_valid/out_ready/out_data): eight items per input item,
// each a filtered 16-bit sample; last_of_byte marks the eighth.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
// write only while no byte is in flight.
// Sequencing: one byte is worked on at a time. Each sample passes through the
// integrator/step update, the gain and the 15-step serial divider of the
// compressor, the filter walking its 57 taps one per cycle, and a hand-off
// to the output register.
// A single output register decouples the receiver: decoding of the next bit
// runs while a sample waits; a stalled receiver holds the sequencer only when
// the next sample is ready. The next byte is accepted while the last sample
// of the previous one still waits.
// Reset puts all decoder and filter state at its cleared values and the
// config registers at their defaults; no clearing pass is needed.
module cvsd_decoder_fir_postfilter_top
    import cvsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    state_t      state_reg, state_next;
    logic        go_reg, go_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  byte_reg;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg;

    logic [2:0]  history_bits_reg;
    logic [15:0] charge_coef_reg;
    logic [15:0] decay_coef_reg;
    logic [15:0] leak_coef_reg;

    logic               in_fire;
    logic               load_out;
    ctl_t               dec_ctl, fir_ctl;
    logic               cmp_start;
    stat_t              dec_stat, cmp_stat, fir_stat;
    logic signed [31:0] integ;
    logic signed [15:0] cmp_sample;
    logic signed [15:0] fir_y;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign load_out  = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    assign dec_ctl.start = go_reg && (state_reg == ST_DEC);
    assign dec_ctl.clear = in_fire && in_data.run_start;
    assign cmp_start     = go_reg && (state_reg == ST_CMP);
    assign fir_ctl.start = go_reg && (state_reg == ST_FIR);
    assign fir_ctl.clear = in_fire && in_data.run_start;

    cvsd_dec u_dec (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (dec_ctl),
        .bit_in       (byte_reg[bit_cnt_reg]),
        .history_bits (history_bits_reg),
        .charge_coef  (charge_coef_reg),
        .decay_coef   (decay_coef_reg),
        .leak_coef    (leak_coef_reg),
        .stat         (dec_stat),
        .integ        (integ)
    );

    cvsd_cmp u_cmp (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmp_start),
        .integ  (integ),
        .stat   (cmp_stat),
        .sample (cmp_sample)
    );

    cvsd_fir u_fir (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (fir_ctl),
        .sample (cmp_sample),
        .stat   (fir_stat),
        .y      (fir_y)
    );

    // sequencer: one bit at a time through decoder, compressor, filter
    always_comb
    begin
        state_next   = state_reg;
        go_next      = 1'b0;
        bit_cnt_next = bit_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next   = ST_DEC;
                    go_next      = 1'b1;
                    bit_cnt_next = '0;
                end
            end
            ST_DEC:
            begin
                if (dec_stat.done)
                begin
                    state_next = ST_CMP;
                    go_next    = 1'b1;
                end
            end
            ST_CMP:
            begin
                if (cmp_stat.done)
                begin
                    state_next = ST_FIR;
                    go_next    = 1'b1;
                end
            end
            ST_FIR:
            begin
                if (fir_stat.done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (load_out)
                begin
                    if (bit_cnt_reg == 3'd7)
                        state_next = ST_IDLE;
                    else
                    begin
                        state_next   = ST_DEC;
                        go_next      = 1'b1;
                        bit_cnt_next = bit_cnt_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            bit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            bit_cnt_reg   <= bit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            byte_reg <= in_data.data_byte;
        if (load_out)
        begin
            out_data_reg.pcm_sample   <= fir_y;
            out_data_reg.last_of_byte <= (bit_cnt_reg == 3'd7);
        end
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_bits_reg <= 3'd4;
            charge_coef_reg  <= 16'd65360;
            decay_coef_reg   <= 16'd65387;
            leak_coef_reg    <= 16'd64496;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HISTORY_BITS: history_bits_reg <= cfg_data[2:0];
                CFG_CHARGE_COEF:  charge_coef_reg  <= cfg_data;
                CFG_DECAY_COEF:   decay_coef_reg   <= cfg_data;
                CFG_LEAK_COEF:    leak_coef_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_accept_starts_dec: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_DEC) && go_reg)
        else $error("accepted item did not launch decoding");

    a_one_unit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({dec_stat.busy, cmp_stat.busy, fir_stat.busy}))
        else $error("more than one unit busy");

endmodule
